// ===== rtl/core/imne_pkg.sv =====
package imne_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_PITCH_MOD = 3'd0;
	localparam logic [2:0] REG_PITCH_OFF = 3'd1;
	localparam logic [2:0] REG_DUR_MOD   = 3'd2;
	localparam logic [2:0] REG_DUR_OFF   = 3'd3;
	localparam logic [2:0] REG_VEL_ON    = 3'd4;
	localparam logic [2:0] REG_VEL_OFF   = 3'd5;

	// reset values and fallbacks
	localparam logic [7:0] PITCH_MOD_DEF = 8'd88;
	localparam logic [7:0] PITCH_OFF_DEF = 8'd20;
	localparam logic [2:0] DUR_MOD_DEF   = 3'd1;
	localparam logic [2:0] DUR_OFF_DEF   = 3'd0;
	localparam logic [7:0] VEL_DEF       = 8'd80;
	localparam logic [7:0] PITCH_SPAN    = 8'd128;
	localparam logic [2:0] DUR_SPAN      = 3'd5;

	// event bytes
	localparam logic [7:0] DELTA_ZERO = 8'h00;
	localparam logic [7:0] STATUS_ON  = 8'd156;
	localparam logic [7:0] STATUS_OFF = 8'd140;
	localparam logic [11:0] BASE_TICKS = 12'd120;

	// magnitude limit (nine decimal digits) and reciprocal of ten
	localparam logic [30:0] MAG_LIMIT = 31'd1_000_000_000;
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// effective configuration, after out-of-range replacement
	typedef struct packed {
		logic [7:0] pmod;
		logic [7:0] poff;
		logic [2:0] dmod;
		logic [2:0] doff;
		logic [7:0] von;
		logic [7:0] voff;
	} cfg_t;

	// front end -> modulo pipeline
	typedef struct packed {
		logic        neg;
		logic        ge;
		logic [30:0] mag;
		logic [27:0] quo;
	} front_t;

	// modulo pipeline -> formatter
	typedef struct packed {
		logic       neg;
		logic [6:0] rp;
		logic [2:0] rd;
	} res_t;

	// one formatted note
	typedef struct packed {
		logic [7:0] pitch;
		logic [7:0] von;
		logic [7:0] voff;
		logic       two;
		logic [7:0] dhi;
		logic [7:0] dlo;
	} note_t;

	// eight restoring steps of a remainder, one input bit each
	function automatic logic [7:0] mod_chunk(input logic [7:0] r_in, input logic [7:0] bits,
			input logic [7:0] m);
		logic [8:0] t;
		logic [7:0] r;
		r = r_in;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
			end
			r = t[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/integer_to_midi_note_encoder.sv =====
// Path: an accepted input beat is registered in front stages 1 and 2, the modulo stages
// and stage 7, then loaded into the serializer, which drives the first byte on m_tdata.
// Each note is 8 or 9 one-byte output beats; up to 7 items queue in the stages.
// Input beats are taken every cycle while the pipeline has room.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the registers to
// 88, 20, 1, 0, 80, 80.
module integer_to_midi_note_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] seq_value, [31] zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] midi_byte
	output logic        m_tlast,   // last_byte
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import imne_pkg::*;

	logic [7:0] pmod_q, poff_q, von_q, voff_q;
	logic [2:0] dmod_q, doff_q;
	cfg_t       cfg;
	logic [8:0] psum;
	logic [3:0] dsum;
	logic       f_valid, f_ready, m_valid, m_ready;
	front_t     f_data;
	res_t       r_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmod_q <= PITCH_MOD_DEF;
			poff_q <= PITCH_OFF_DEF;
			dmod_q <= DUR_MOD_DEF;
			doff_q <= DUR_OFF_DEF;
			von_q  <= VEL_DEF;
			voff_q <= VEL_DEF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PITCH_MOD: pmod_q <= cfg_data;
				REG_PITCH_OFF: poff_q <= cfg_data;
				REG_DUR_MOD:   dmod_q <= cfg_data[2:0];
				REG_DUR_OFF:   doff_q <= cfg_data[2:0];
				REG_VEL_ON:    von_q  <= cfg_data;
				REG_VEL_OFF:   voff_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// effective values, out-of-range fields replaced
	always_comb begin
		cfg.pmod = (pmod_q == 8'd0 || pmod_q > PITCH_SPAN) ? PITCH_MOD_DEF : pmod_q;
		psum     = {1'b0, poff_q} + {1'b0, cfg.pmod};
		cfg.poff = (psum > {1'b0, PITCH_SPAN}) ? ((PITCH_SPAN - cfg.pmod) >> 1) : poff_q;
		cfg.dmod = (dmod_q == 3'd0 || dmod_q > DUR_SPAN) ? DUR_MOD_DEF : dmod_q;
		dsum     = {1'b0, doff_q} + {1'b0, cfg.dmod};
		cfg.doff = (dsum > {1'b0, DUR_SPAN}) ? DUR_OFF_DEF : doff_q;
		cfg.von  = (von_q == 8'd0 || von_q[7]) ? VEL_DEF : von_q;
		cfg.voff = (voff_q == 8'd0 || voff_q[7]) ? VEL_DEF : voff_q;
	end

	imne_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata[30:0]),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_data (f_data)
	);

	imne_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_data  (f_data),
		.out_valid(m_valid),
		.out_ready(m_ready),
		.out_data (r_data)
	);

	imne_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (m_valid),
		.in_ready (m_ready),
		.in_data  (r_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

endmodule

// ===== rtl/core/imne_front.sv =====
module imne_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [30:0]     in_value,
	output logic            out_valid,
	input  logic            out_ready,
	output imne_pkg::front_t out_data
);
	import imne_pkg::*;

	logic        v_s1, v_s2;
	logic        rdy_s1, rdy_s2;
	logic        neg_s1;
	logic        ge_s1;
	logic [30:0] mag_s1;
	logic [62:0] prod;
	front_t      d_s2;
	logic [30:0] mag_in;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// magnitude of the 31-bit two's complement value
	assign mag_in = in_value[30] ? (~in_value + 31'd1) : in_value;

	// stage 1: sign, magnitude and digit-count check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			neg_s1 <= in_value[30];
			mag_s1 <= mag_in;
			ge_s1  <= (mag_in >= MAG_LIMIT);
		end
	end

	// stage 2: magnitude divided by ten through the reciprocal
	assign prod = 63'(mag_s1) * 63'(RECIP_TEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			d_s2.neg <= neg_s1;
			d_s2.ge  <= ge_s1;
			d_s2.mag <= mag_s1;
			d_s2.quo <= prod[RECIP_SHIFT +: 28];
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

// ===== rtl/core/imne_mod.sv =====
module imne_mod (
	input  logic             clk,
	input  logic             arst_n,
	input  imne_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  imne_pkg::front_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output imne_pkg::res_t   out_data
);
	import imne_pkg::*;

	localparam int NSTG = 4;

	logic        v_s   [NSTG];
	logic        rdy_s [NSTG];
	logic        neg_s [NSTG];
	logic [31:0] val_s [NSTG];
	logic [7:0]  rp_s  [NSTG];
	logic [7:0]  rd_s  [NSTG];
	logic [31:0] val_in;

	// trimmed magnitude: one division by ten at most
	assign val_in = in_data.ge ? {4'b0, in_data.quo} : {1'b0, in_data.mag};

	// ready chain, back to front
	always_comb begin
		for (int k = NSTG - 1; k >= 0; k--) begin
			if (k == NSTG - 1) begin
				rdy_s[k] = !v_s[k] || out_ready;
			end else begin
				rdy_s[k] = !v_s[k] || rdy_s[k + 1];
			end
		end
	end

	assign in_ready = rdy_s[0];

	// one byte of the magnitude per stage, both remainders side by side
	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		logic        v_prev;
		logic        neg_prev;
		logic [31:0] val_prev;
		logic [7:0]  rp_prev, rd_prev;

		if (k == 0) begin : g_first
			assign v_prev   = in_valid;
			assign neg_prev = in_data.neg;
			assign val_prev = val_in;
			assign rp_prev  = 8'd0;
			assign rd_prev  = 8'd0;
		end else begin : g_next
			assign v_prev   = v_s[k - 1];
			assign neg_prev = neg_s[k - 1];
			assign val_prev = val_s[k - 1];
			assign rp_prev  = rp_s[k - 1];
			assign rd_prev  = rd_s[k - 1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k]) begin
				neg_s[k] <= neg_prev;
				val_s[k] <= val_prev;
				rp_s[k]  <= mod_chunk(rp_prev, val_prev[31 - 8 * k -: 8], cfg.pmod);
				rd_s[k]  <= mod_chunk(rd_prev, val_prev[31 - 8 * k -: 8], {5'b0, cfg.dmod});
			end
		end
	end

	assign out_valid     = v_s[NSTG - 1];
	assign out_data.neg  = neg_s[NSTG - 1];
	assign out_data.rp   = rp_s[NSTG - 1][6:0];
	assign out_data.rd   = rd_s[NSTG - 1][2:0];

endmodule

// ===== rtl/core/imne_ser.sv =====
module imne_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  imne_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  imne_pkg::res_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last
);
	import imne_pkg::*;

	// byte positions within one note
	localparam logic [3:0] POS_DELTA0   = 4'd0;
	localparam logic [3:0] POS_STAT_ON  = 4'd1;
	localparam logic [3:0] POS_PITCH_ON = 4'd2;
	localparam logic [3:0] POS_VEL_ON   = 4'd3;
	localparam logic [3:0] POS_DHI      = 4'd4;
	localparam logic [3:0] POS_DLO      = 4'd5;
	localparam logic [3:0] POS_STAT_OFF = 4'd6;
	localparam logic [3:0] POS_PITCH_OF = 4'd7;
	localparam logic [3:0] POS_VEL_OFF  = 4'd8;

	logic       v_s7, rdy_s7;
	note_t      note_s7, note_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       take, at_end, load;
	logic [7:0] rp_fl;
	logic [2:0] rd_fl;
	logic [2:0] dexp;
	logic [11:0] ticks;
	note_t      note_d;

	// floored remainders, offsets and the delta time
	always_comb begin
		rp_fl = (in_data.neg && in_data.rp != 7'd0) ?
			(cfg.pmod - {1'b0, in_data.rp}) : {1'b0, in_data.rp};
		rd_fl = (in_data.neg && in_data.rd != 3'd0) ? (cfg.dmod - in_data.rd) : in_data.rd;
		dexp  = rd_fl + cfg.doff;
		ticks = BASE_TICKS << dexp;
		note_d.pitch = rp_fl + cfg.poff;
		note_d.von   = cfg.von;
		note_d.voff  = cfg.voff;
		note_d.two   = (ticks[11:7] != 5'd0);
		note_d.dhi   = {3'b100, ticks[11:7]};
		note_d.dlo   = {1'b0, ticks[6:0]};
	end

	// beat handshake of the byte serializer
	assign take   = busy_q && out_ready;
	assign at_end = (idx_q == POS_VEL_OFF);
	assign load   = v_s7 && (!busy_q || (take && at_end));
	assign rdy_s7 = !v_s7 || !busy_q || (take && at_end);
	assign in_ready = rdy_s7;

	// stage 7: formatted note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (rdy_s7) begin
			v_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			note_s7 <= note_d;
		end
	end

	// serializer: one byte per beat, one-byte deltas skip the high byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= POS_DELTA0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= POS_DELTA0;
		end else if (take) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else if (idx_q == POS_VEL_ON && !note_q.two) begin
				idx_q <= POS_DLO;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			note_q <= note_s7;
		end
	end

	// output byte select
	always_comb begin
		case (idx_q)
			POS_DELTA0:   out_byte = DELTA_ZERO;
			POS_STAT_ON:  out_byte = STATUS_ON;
			POS_PITCH_ON: out_byte = note_q.pitch;
			POS_VEL_ON:   out_byte = note_q.von;
			POS_DHI:      out_byte = note_q.dhi;
			POS_DLO:      out_byte = note_q.dlo;
			POS_STAT_OFF: out_byte = STATUS_OFF;
			POS_PITCH_OF: out_byte = note_q.pitch;
			POS_VEL_OFF:  out_byte = note_q.voff;
			default:      out_byte = DELTA_ZERO;
		endcase
	end

	assign out_valid = busy_q;
	assign out_last  = at_end;

endmodule
